FILE: design/lpc_pkg.sv
// Shared types, register codes and generator jump tables for the position checker.
// No dependencies; the lane and core files refer to this package by scoped names.
package lpc_pkg;

    localparam int LANE_LAT     = 7;
    localparam int JUMP_ENTRIES = 513;

    localparam logic [47:0] LCG_MUL = 48'h0005DEECE66D;
    localparam logic [47:0] LCG_INC = 48'h00000000000B;
    localparam logic [47:0] CX_MUL  = 48'd341873128712;
    localparam logic [47:0] CZ_MUL  = 48'd132897987541;
    localparam logic [31:0] RX_MUL  = 32'd3129871;
    localparam logic [33:0] RZ_MUL  = 34'd116129781;
    localparam logic [33:0] RQ_MUL  = 34'd42317861;
    localparam logic [33:0] RL_MUL  = 34'd11;

    localparam logic [1:0] MODE_SINGLE   = 2'd3;
    localparam logic [1:0] MODE_DOUBLE_2 = 2'd2;
    localparam logic [1:0] VERSION_SEED  = 2'd2;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_VERSION = 3'd1;
    localparam logic [2:0] REG_WSEED   = 3'd2;
    localparam logic [2:0] REG_LAYER_Y = 3'd3;
    localparam logic [2:0] REG_TAG     = 3'd4;
    localparam logic [2:0] REG_COUNT   = 3'd5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef struct packed {
        logic signed [6:0] dx;
        logic signed [6:0] dz;
        logic signed [3:0] exact;
        logic signed [3:0] least;
        logic signed [3:0] most;
        logic signed [2:0] rot;
    } rule_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         version;
        logic [63:0]        wseed;
        logic signed [11:0] layer_y;
    } cfg_t;

    typedef logic [47:0] jump_tab_t [256];

    // Entry j of the odd table jumps 2j+1 steps, of the even table 2j+2 steps
    function automatic jump_tab_t make_jump_tab(input bit want_mul, input bit even_k);
        jump_tab_t   tab;
        logic [47:0] a;
        logic [47:0] b;
        a = 48'd1;
        b = 48'd0;
        for (int k = 0; k < 256; k++)
        begin
            tab[k] = 48'd0;
        end
        for (int k = 0; k < JUMP_ENTRIES; k++)
        begin
            if (!even_k && (k % 2 == 1))
            begin
                tab[k / 2] = want_mul ? a : b;
            end
            if (even_k && (k % 2 == 0) && k > 0)
            begin
                tab[k / 2 - 1] = want_mul ? a : b;
            end
            a = 48'(a * LCG_MUL);
            b = 48'(b * LCG_MUL + LCG_INC);
        end
        return tab;
    endfunction

    localparam jump_tab_t JUMP_MUL_ODD  = make_jump_tab(1'b1, 1'b0);
    localparam jump_tab_t JUMP_ADD_ODD  = make_jump_tab(1'b0, 1'b0);
    localparam jump_tab_t JUMP_MUL_EVEN = make_jump_tab(1'b1, 1'b1);
    localparam jump_tab_t JUMP_ADD_EVEN = make_jump_tab(1'b0, 1'b1);

endpackage

FILE: design/lpc_if.sv
// Handshake channels of the position checker: item input, result output, register writes.
// Depends on nothing; widths follow the item and result fields.
interface lpc_item_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [2:0]  entry_index;
    logic [6:0]  offset_x;
    logic [6:0]  offset_z;
    logic [3:0]  want_depth;
    logic [3:0]  least_depth;
    logic [3:0]  most_depth;
    logic [2:0]  want_rotation;
    logic [25:0] pos_x;
    logic [25:0] pos_z;
    modport source (output valid, operation, entry_index, offset_x, offset_z, want_depth,
                    least_depth, most_depth, want_rotation, pos_x, pos_z, input ready);
    modport sink (input valid, operation, entry_index, offset_x, offset_z, want_depth,
                  least_depth, most_depth, want_rotation, pos_x, pos_z, output ready);
endinterface

interface lpc_res_if;
    logic        valid;
    logic        ready;
    logic        match_found;
    logic [25:0] match_x;
    logic [25:0] match_z;
    logic [8:0]  match_tag;
    modport source (output valid, match_found, match_x, match_z, match_tag, input ready);
    modport sink (input valid, match_found, match_x, match_z, match_tag, output ready);
endinterface

interface lpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: design/lpc_lane.sv
// One constraint lane: seven register stages from position to pass/fail for one rule.
// Depends on lpc_pkg for the rule and configuration types and the jump tables.
module lpc_lane
(
    input  logic                clk,
    input  logic                adv,
    input  lpc_pkg::rule_t      rule,
    input  logic                active,
    input  logic [25:0]         pos_x,
    input  logic [25:0]         pos_z,
    input  lpc_pkg::cfg_t       cfg,
    output logic                lane_ok
);

    lpc_pkg::rule_t rule_pipe_reg [6];
    logic [5:0]     act_pipe_reg;

    // stage 1
    logic signed [26:0] wx_reg, wx_next, wz_reg, wz_next;
    // stage 2
    logic [47:0] bx_reg, bx_next, bz_reg, bz_next, jm2_reg, jm2_next, ja2_reg, ja2_next;
    logic [33:0] xp_reg, xp_next, zt_reg, zt_next;
    // stage 3
    logic [47:0] s3_reg, s3_next, jm3_reg, ja3_reg;
    logic [33:0] l3_reg, l3_next;
    // stage 4
    logic [47:0] p0_reg, p0_next, ja4_reg;
    logic [23:0] p1_reg, p1_next, p2_reg, p2_next;
    logic [33:0] lsq_reg, lsq_next, l11_reg, l11_next;
    // stage 5
    logic [47:0] s5_reg, s5_next;
    logic [1:0]  rot5_reg, rot5_next;
    // stage 6
    logic [6:0]  nsum_reg, nsum_next;
    logic        rok6_reg, rok6_next;
    // stage 7
    logic        ok_reg, ok_next;

    logic [7:0]  col;
    logic [7:0]  tidx;
    logic        tsel_even;
    logic [22:0] ncx, ncz;
    logic [31:0] xprod;
    logic [47:0] ws_add;
    logic [33:0] r34;
    logic [4:0]  fold;
    logic [2:0]  depth;
    logic signed [3:0] dsig;
    lpc_pkg::rule_t r6;

    always_comb
    begin
        wx_next = {pos_x[25], pos_x} + 27'(rule.dx);
        wz_next = {pos_z[25], pos_z} + 27'(rule.dz);

        // chunk coordinates are the floor of the column position by sixteen
        ncx = wx_reg[26:4];
        ncz = wz_reg[26:4];
        bx_next = 48'({{25{ncx[22]}}, ncx} * lpc_pkg::CX_MUL);
        bz_next = 48'({{25{ncz[22]}}, ncz} * lpc_pkg::CZ_MUL);
        col = {wx_reg[3:0], wz_reg[3:0]};
        case (cfg.mode)
            lpc_pkg::MODE_SINGLE:
            begin
                tidx      = {1'b0, col[7:1]};
                tsel_even = col[0];
            end
            lpc_pkg::MODE_DOUBLE_2:
            begin
                tidx      = col;
                tsel_even = 1'b1;
            end
            default:
            begin
                tidx      = col;
                tsel_even = 1'b0;
            end
        endcase
        jm2_next = tsel_even ? lpc_pkg::JUMP_MUL_EVEN[tidx] : lpc_pkg::JUMP_MUL_ODD[tidx];
        ja2_next = tsel_even ? lpc_pkg::JUMP_ADD_EVEN[tidx] : lpc_pkg::JUMP_ADD_ODD[tidx];
        // only bits 32..33 of the hash matter, so work modulo 2^34
        xprod   = 32'({{5{wx_reg[26]}}, wx_reg} * lpc_pkg::RX_MUL);
        xp_next = {{2{xprod[31]}}, xprod};
        zt_next = 34'({{7{wz_reg[26]}}, wz_reg} * lpc_pkg::RZ_MUL);

        ws_add = (cfg.version == lpc_pkg::VERSION_SEED && cfg.mode == lpc_pkg::MODE_SINGLE
                  && cfg.wseed != 64'd0) ? cfg.wseed[47:0] : 48'd0;
        s3_next = (bx_reg + bz_reg + ws_add) ^ lpc_pkg::LCG_MUL;
        l3_next = xp_reg ^ zt_reg ^ {{22{cfg.layer_y[11]}}, cfg.layer_y};

        // low 48 bits of the 48 by 48 product from three 24 by 24 parts
        p0_next  = 48'(s3_reg[23:0]) * 48'(jm3_reg[23:0]);
        p1_next  = 24'(s3_reg[47:24] * jm3_reg[23:0]);
        p2_next  = 24'(s3_reg[23:0] * jm3_reg[47:24]);
        lsq_next = 34'(l3_reg * l3_reg);
        l11_next = 34'(l3_reg * lpc_pkg::RL_MUL);

        s5_next   = p0_reg + {p1_reg + p2_reg, 24'd0} + ja4_reg;
        r34       = 34'(lsq_reg * lpc_pkg::RQ_MUL) + l11_reg;
        rot5_next = r34[33:32];

        // sixteen is one modulo five: sum the hex digits of seed >> 17
        nsum_next = 7'(s5_reg[20:17]) + 7'(s5_reg[24:21]) + 7'(s5_reg[28:25])
                  + 7'(s5_reg[32:29]) + 7'(s5_reg[36:33]) + 7'(s5_reg[40:37])
                  + 7'(s5_reg[44:41]) + 7'(s5_reg[47:45]);
        rok6_next = (rule_pipe_reg[4].rot == -3'sd1)
                 || (rule_pipe_reg[4].rot == $signed({1'b0, rot5_reg}));

        fold = 5'(nsum_reg[3:0]) + 5'(nsum_reg[6:4]);
        if (fold >= 5'd20)
        begin
            depth = 3'(fold - 5'd20);
        end
        else if (fold >= 5'd15)
        begin
            depth = 3'(fold - 5'd15);
        end
        else if (fold >= 5'd10)
        begin
            depth = 3'(fold - 5'd10);
        end
        else if (fold >= 5'd5)
        begin
            depth = 3'(fold - 5'd5);
        end
        else
        begin
            depth = fold[2:0];
        end
        dsig = $signed({1'b0, depth});
        r6   = rule_pipe_reg[5];
        ok_next = !act_pipe_reg[5]
               || (rok6_reg
                   && (r6.exact == -4'sd1 || r6.exact == dsig)
                   && (r6.least == -4'sd1 || dsig >= r6.least)
                   && (r6.most == -4'sd1 || dsig <= r6.most));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rule_pipe_reg[0] <= rule;
            act_pipe_reg[0]  <= active;
            for (int k = 1; k < 6; k++)
            begin
                rule_pipe_reg[k] <= rule_pipe_reg[k-1];
                act_pipe_reg[k]  <= act_pipe_reg[k-1];
            end
            wx_reg   <= wx_next;
            wz_reg   <= wz_next;
            bx_reg   <= bx_next;
            bz_reg   <= bz_next;
            jm2_reg  <= jm2_next;
            ja2_reg  <= ja2_next;
            xp_reg   <= xp_next;
            zt_reg   <= zt_next;
            s3_reg   <= s3_next;
            jm3_reg  <= jm2_reg;
            ja3_reg  <= ja2_reg;
            l3_reg   <= l3_next;
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            ja4_reg  <= ja3_reg;
            lsq_reg  <= lsq_next;
            l11_reg  <= l11_next;
            s5_reg   <= s5_next;
            rot5_reg <= rot5_next;
            nsum_reg <= nsum_next;
            rok6_reg <= rok6_next;
            ok_reg   <= ok_next;
        end
    end

    assign lane_ok = ok_reg;

endmodule

FILE: design/lcg_pattern_position_checker_core.sv
// Top level of the position checker: registers, constraint table, lanes and result stage.
// Depends on lpc_pkg, the channels in lpc_if and the lane in lpc_lane.
//
//  channel  | modport | moves
//  ---------+---------+----------------------------------------------
//  item     | sink    | load of one constraint entry, or test position
//  result   | source  | match flag, echoed position, tag
//  cfg      | sink    | register write, index and 64-bit data
//
// Every item passes from acceptance to result through seven lane stages
// (seed multiplies, the split 48-bit jump multiply, digit fold) and then the result register.
// One item is accepted per cycle; the whole pipeline holds while a result waits.
// Reset clears the valid bits and registers; the constraint table holds no reset.
// Register writes are always taken.
module lcg_pattern_position_checker_core
#(
    parameter int MAX_CONSTRAINTS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    lpc_cfg_if.sink    cfg,
    lpc_item_if.sink   item,
    lpc_res_if.source  result
);

    typedef struct packed {
        logic        op;
        logic        any;
        logic [25:0] px;
        logic [25:0] pz;
    } side_t;

    localparam int LAT = lpc_pkg::LANE_LAT;

    logic [1:0]         mode_reg;
    logic [1:0]         version_reg;
    logic [63:0]        wseed_reg;
    logic signed [11:0] layer_y_reg;
    logic [8:0]         tag_reg;
    logic [3:0]         count_reg;

    lpc_pkg::rule_t  table_reg [MAX_CONSTRAINTS];
    lpc_pkg::rule_t  new_rule;
    lpc_pkg::cfg_t   lane_cfg;
    logic [MAX_CONSTRAINTS-1:0] active;
    logic [MAX_CONSTRAINTS-1:0] lane_ok;

    logic [LAT-1:0] valid_reg;
    side_t          side_reg [LAT];
    side_t          side_next;

    logic        out_valid_reg;
    logic        out_found_reg, out_found_next;
    logic [25:0] out_x_reg, out_z_reg;
    logic [8:0]  out_tag_reg;
    logic        adv;
    logic        load_wr;

    assign adv        = !out_valid_reg || result.ready;
    assign item.ready = adv;
    assign cfg.ready  = 1'b1;
    assign load_wr    = item.valid && adv && item.operation == lpc_pkg::OP_LOAD;

    assign new_rule = '{dx: item.offset_x, dz: item.offset_z, exact: item.want_depth,
                        least: item.least_depth, most: item.most_depth,
                        rot: item.want_rotation};
    assign lane_cfg = '{mode: mode_reg, version: version_reg, wseed: wseed_reg,
                        layer_y: layer_y_reg};

    always_comb
    begin
        for (int i = 0; i < MAX_CONSTRAINTS; i++)
        begin
            active[i] = 32'(count_reg) > i;
        end
        side_next = '{op: item.operation, any: count_reg != 4'd0,
                      px: item.pos_x, pz: item.pos_z};
        out_found_next = side_reg[LAT-1].op && side_reg[LAT-1].any && (&lane_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= '0;
            version_reg <= '0;
            wseed_reg   <= '0;
            layer_y_reg <= '0;
            tag_reg     <= '0;
            count_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                lpc_pkg::REG_MODE:    mode_reg    <= cfg.data[1:0];
                lpc_pkg::REG_VERSION: version_reg <= cfg.data[1:0];
                lpc_pkg::REG_WSEED:   wseed_reg   <= cfg.data;
                lpc_pkg::REG_LAYER_Y: layer_y_reg <= cfg.data[11:0];
                lpc_pkg::REG_TAG:     tag_reg     <= cfg.data[8:0];
                lpc_pkg::REG_COUNT:   count_reg   <= cfg.data[3:0];
                default:              ;
            endcase
        end
    end

    // drop loads aimed past the last entry
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_CONSTRAINTS; i++)
        begin
            if (load_wr && {29'd0, item.entry_index} == 32'(i))
            begin
                table_reg[i] <= new_rule;
            end
        end
    end

    generate
        for (genvar g = 0; g < MAX_CONSTRAINTS; g++)
        begin : g_lane
            lpc_lane u_lane
            (
                .clk     (clk),
                .adv     (adv),
                .rule    (table_reg[g]),
                .active  (active[g]),
                .pos_x   (item.pos_x),
                .pos_z   (item.pos_z),
                .cfg     (lane_cfg),
                .lane_ok (lane_ok[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[LAT-2:0], item.valid};
            out_valid_reg <= valid_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k < LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            out_found_reg <= out_found_next;
            out_x_reg     <= side_reg[LAT-1].op ? side_reg[LAT-1].px : 26'd0;
            out_z_reg     <= side_reg[LAT-1].op ? side_reg[LAT-1].pz : 26'd0;
            out_tag_reg   <= side_reg[LAT-1].op ? tag_reg : 9'd0;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.match_found = out_found_reg;
    assign result.match_x     = out_x_reg;
    assign result.match_z     = out_z_reg;
    assign result.match_tag   = out_tag_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg) && $stable(out_valid_reg))
        else $error("pipeline moved during a stall");

    a_tag_source: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.match_tag == tag_reg || result.match_tag == 9'd0))
        else $error("result tag does not come from the tag register");

    a_no_rules: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && count_reg == 4'd0 |-> !result.match_found)
        else $error("match reported with no active constraints");

endmodule
